[rtl/core/tilt_pkg.sv]
package tilt_pkg;

  typedef enum logic [1:0] {
    AXIS_X,
    AXIS_Y,
    AXIS_Z,
    AXIS_NONE
  } axis_t;

  typedef enum logic [1:0] {
    KIND_NORMAL,
    KIND_ZERO,
    KIND_NINETY,
    KIND_UNDEF
  } kind_t;

  typedef struct packed {
    kind_t kind;
    logic  neg;
    logic  pass_is_den;
  } tag_t;

  localparam int ZW = 19;
  localparam int ATAN_LEN = 24;

  localparam logic [15:0] ATAN_Q16 [ATAN_LEN] = '{
    16'd51472, 16'd30386, 16'd16055, 16'd8150, 16'd4091, 16'd2047, 16'd1024, 16'd512,
    16'd256, 16'd128, 16'd64, 16'd32, 16'd16, 16'd8, 16'd4, 16'd2,
    16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0
  };

  localparam logic [15:0] INV_GAIN_Q16 = 16'd39797;

  // Degrees = floor(z * 9000 / (157 * 65536)), the same ratio as 18000 / (314 * 65536).
  localparam longint unsigned DEG_MUL = 64'd9000;
  localparam longint unsigned DEG_DIV = 64'd157 * 64'd65536;
  localparam int RECIP_SHIFT = 44;
  localparam longint unsigned DEG_RECIP = (64'd1 << RECIP_SHIFT) / DEG_DIV;
  localparam logic [8:0] DEG_MAX = 9'd90;

endpackage

[rtl/core/tilt_mag_cell.sv]
module tilt_mag_cell #(
  parameter int W     = 33,
  parameter int PW    = 13,
  parameter int SHIFT = 0
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic signed [W-1:0]   in_x,
  input  logic signed [W-1:0]   in_y,
  input  logic [PW-1:0]         in_pass,
  input  tilt_pkg::tag_t        in_tag,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [W-1:0]   out_x,
  output logic signed [W-1:0]   out_y,
  output logic [PW-1:0]         out_pass,
  output tilt_pkg::tag_t        out_tag
);
  import tilt_pkg::*;

  logic signed [W-1:0] xs;
  logic signed [W-1:0] ys;
  logic signed [W-1:0] x_next;
  logic signed [W-1:0] y_next;

  assign xs = in_x >>> SHIFT;
  assign ys = in_y >>> SHIFT;
  assign x_next = in_y[W-1] ? in_x - ys : in_x + ys;
  assign y_next = in_y[W-1] ? in_y + xs : in_y - xs;

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_x    <= x_next;
      out_y    <= y_next;
      out_pass <= in_pass;
      out_tag  <= in_tag;
    end
  end

endmodule

[rtl/core/tilt_ang_cell.sv]
module tilt_ang_cell #(
  parameter int W     = 33,
  parameter int SHIFT = 0
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [W-1:0]           in_x,
  input  logic signed [W-1:0]           in_y,
  input  logic signed [tilt_pkg::ZW-1:0] in_z,
  input  tilt_pkg::tag_t                in_tag,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [W-1:0]           out_x,
  output logic signed [W-1:0]           out_y,
  output logic signed [tilt_pkg::ZW-1:0] out_z,
  output tilt_pkg::tag_t                out_tag
);
  import tilt_pkg::*;

  localparam logic signed [ZW-1:0] STEP = signed'(ZW'(ATAN_Q16[SHIFT]));

  logic signed [W-1:0]  xs;
  logic signed [W-1:0]  ys;
  logic signed [W-1:0]  x_next;
  logic signed [W-1:0]  y_next;
  logic signed [ZW-1:0] z_next;

  assign xs = in_x >>> SHIFT;
  assign ys = in_y >>> SHIFT;
  assign x_next = in_y[W-1] ? in_x - ys : in_x + ys;
  assign y_next = in_y[W-1] ? in_y + xs : in_y - xs;
  assign z_next = in_y[W-1] ? in_z - STEP : in_z + STEP;

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_x   <= x_next;
      out_y   <= y_next;
      out_z   <= z_next;
      out_tag <= in_tag;
    end
  end

endmodule

[rtl/core/tilt_deg.sv]
module tilt_deg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [tilt_pkg::ZW-1:0] in_z,
  input  tilt_pkg::tag_t                 in_tag,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [7:0]                     out_angle,
  output logic                           out_undef
);
  import tilt_pkg::*;

  logic                a_valid;
  logic                a_ready;
  logic [31:0]         a_prod;
  tag_t                a_tag;
  logic                b_valid;
  logic                b_ready;
  logic [31:0]         b_prod;
  logic [8:0]          b_quot;
  tag_t                b_tag;
  logic                c_ready;

  logic [ZW-2:0]       z_clamp;
  logic [63:0]         recip_prod;
  logic [32:0]         rem;
  logic [8:0]          quot;
  logic [6:0]          deg_mag;
  logic [7:0]          angle_next;
  logic                undef_next;

  assign c_ready  = !out_valid || out_ready;
  assign b_ready  = !b_valid || c_ready;
  assign a_ready  = !a_valid || b_ready;
  assign in_ready = a_ready;

  assign z_clamp    = in_z[ZW-1] ? '0 : in_z[ZW-2:0];
  assign recip_prod = 64'(a_prod) * DEG_RECIP;
  assign rem        = 33'(b_prod) - 33'(b_quot) * 33'(DEG_DIV);
  assign quot       = (rem >= 33'(DEG_DIV)) ? b_quot + 9'd1 : b_quot;
  assign deg_mag    = (quot > DEG_MAX) ? 7'(DEG_MAX) : quot[6:0];

  always_comb begin
    angle_next = 8'd0;
    undef_next = 1'b0;
    unique case (b_tag.kind)
      KIND_NORMAL: angle_next = {1'b0, deg_mag};
      KIND_NINETY: angle_next = 8'(DEG_MAX);
      KIND_ZERO:   angle_next = 8'd0;
      KIND_UNDEF:  undef_next = 1'b1;
      default:     undef_next = 1'b1;
    endcase
    if (b_tag.neg) begin
      angle_next = 8'd0 - angle_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid <= in_valid;
      end
      if (b_ready) begin
        b_valid <= a_valid;
      end
      if (c_ready) begin
        out_valid <= b_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && in_valid) begin
      a_prod <= 32'(z_clamp) * 32'(DEG_MUL);
      a_tag  <= in_tag;
    end
    if (b_ready && a_valid) begin
      b_prod <= a_prod;
      b_quot <= recip_prod[RECIP_SHIFT+8:RECIP_SHIFT];
      b_tag  <= a_tag;
    end
    if (c_ready && b_valid) begin
      out_angle <= angle_next;
      out_undef <= undef_next;
    end
  end

endmodule

[rtl/core/accel_tilt_angle.sv]
// Tilt angle in whole degrees of one axis from a signed three-axis acceleration sample.
// The block takes one item per cycle while the output side accepts, and returns one result
// per item, in order, through one input stage, a row of magnitude CORDIC cells, one gain
// multiply stage, a row of angle CORDIC cells and three degree scaling stages, the last being
// the output register. Every stage holds its item when the next one is full, so bubbles close
// up and input is taken while a result waits.
// Axis 3, or zero over zero, gives angle 0 with the undefined flag set.
module accel_tilt_angle #(
  parameter int CORDIC_STAGES = 16,
  parameter int SAMPLE_BITS   = 13
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     s_tvalid,
  output logic                                     s_tready,
  input  logic [((3*SAMPLE_BITS+7)/8)*8-1:0]       s_tdata,  // accel_x, accel_y, accel_z
  input  logic [1:0]                               s_tuser,  // axis_sel
  output logic                                     m_tvalid,
  input  logic                                     m_tready,
  output logic [7:0]                               m_tdata,  // angle_deg
  output logic [0:0]                               m_tuser   // undefined
);
  import tilt_pkg::*;

  localparam int SB = SAMPLE_BITS;
  localparam int N  = CORDIC_STAGES;
  localparam int W  = SAMPLE_BITS + 20;

  function automatic logic [SB-1:0] absval(input logic [SB-1:0] v);
    return v[SB-1] ? SB'(-v) : v;
  endfunction

  logic [SB-1:0] ax;
  logic [SB-1:0] ay;
  logic [SB-1:0] az;
  logic [SB-1:0] abs_x;
  logic [SB-1:0] abs_y;
  logic [SB-1:0] abs_z;
  logic [SB-1:0] sel_a;
  logic [SB-1:0] sel_b;
  logic [SB-1:0] sel_pass;
  logic          num_zero;
  logic          den_zero;
  logic          sel_bad;
  tag_t          sel_tag;

  logic          p_valid;
  logic          p_ready;
  logic [SB-1:0] p_a;
  logic [SB-1:0] p_b;
  logic [SB-1:0] p_pass;
  tag_t          p_tag;

  logic                mv    [N+1];
  logic                mr    [N+1];
  logic signed [W-1:0] mx    [N+1];
  logic signed [W-1:0] my    [N+1];
  logic [SB-1:0]       mpass [N+1];
  tag_t                mtag  [N+1];

  logic                g_valid;
  logic                g_ready;
  logic [W-1:0]        g_mag;
  logic [SB-1:0]       g_pass;
  tag_t                g_tag;
  logic [W+15:0]       gain_prod;
  logic signed [W-1:0] g_pass_q16;

  logic                 av   [N+1];
  logic                 ar   [N+1];
  logic signed [W-1:0]  axv  [N+1];
  logic signed [W-1:0]  ayv  [N+1];
  logic signed [ZW-1:0] azv  [N+1];
  tag_t                 atag [N+1];

  assign ax = s_tdata[SB-1:0];
  assign ay = s_tdata[2*SB-1:SB];
  assign az = s_tdata[3*SB-1:2*SB];
  assign abs_x = absval(ax);
  assign abs_y = absval(ay);
  assign abs_z = absval(az);

  always_comb begin
    sel_a               = abs_y;
    sel_b               = abs_z;
    sel_pass            = abs_x;
    num_zero            = 1'b0;
    den_zero            = 1'b0;
    sel_bad             = 1'b0;
    sel_tag.neg         = 1'b0;
    sel_tag.pass_is_den = 1'b0;
    unique case (s_tuser)
      AXIS_X: begin
        sel_a       = abs_y;
        sel_b       = abs_z;
        sel_pass    = abs_x;
        num_zero    = (ax == '0);
        den_zero    = (ay == '0) && (az == '0);
        sel_tag.neg = ax[SB-1];
      end
      AXIS_Y: begin
        sel_a       = abs_x;
        sel_b       = abs_z;
        sel_pass    = abs_y;
        num_zero    = (ay == '0);
        den_zero    = (ax == '0) && (az == '0);
        sel_tag.neg = ay[SB-1];
      end
      AXIS_Z: begin
        sel_a               = abs_x;
        sel_b               = abs_y;
        sel_pass            = abs_z;
        num_zero            = (ax == '0) && (ay == '0);
        den_zero            = (az == '0);
        sel_tag.neg         = az[SB-1];
        sel_tag.pass_is_den = 1'b1;
      end
      default: sel_bad = 1'b1;
    endcase
    if (sel_bad || (num_zero && den_zero)) begin
      sel_tag.kind = KIND_UNDEF;
    end else if (den_zero) begin
      sel_tag.kind = KIND_NINETY;
    end else if (num_zero) begin
      sel_tag.kind = KIND_ZERO;
    end else begin
      sel_tag.kind = KIND_NORMAL;
    end
  end

  assign p_ready  = !p_valid || mr[0];
  assign s_tready = p_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (p_ready) begin
      p_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (p_ready && s_tvalid) begin
      p_a    <= sel_a;
      p_b    <= sel_b;
      p_pass <= sel_pass;
      p_tag  <= sel_tag;
    end
  end

  assign mv[0]    = p_valid;
  assign mx[0]    = signed'({{(W-SB-16){1'b0}}, p_a, 16'd0});
  assign my[0]    = signed'({{(W-SB-16){1'b0}}, p_b, 16'd0});
  assign mpass[0] = p_pass;
  assign mtag[0]  = p_tag;

  for (genvar i = 0; i < N; i++) begin : g_mag_row
    tilt_mag_cell #(
      .W     (W),
      .PW    (SB),
      .SHIFT (i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (mv[i]),
      .in_ready  (mr[i]),
      .in_x      (mx[i]),
      .in_y      (my[i]),
      .in_pass   (mpass[i]),
      .in_tag    (mtag[i]),
      .out_valid (mv[i+1]),
      .out_ready (mr[i+1]),
      .out_x     (mx[i+1]),
      .out_y     (my[i+1]),
      .out_pass  (mpass[i+1]),
      .out_tag   (mtag[i+1])
    );
  end

  assign g_ready   = !g_valid || ar[0];
  assign mr[N]     = g_ready;
  assign gain_prod = (W+16)'(unsigned'(mx[N])) * (W+16)'(INV_GAIN_Q16);

  always_ff @(posedge clk) begin
    if (rst) begin
      g_valid <= 1'b0;
    end else if (g_ready) begin
      g_valid <= mv[N];
    end
  end

  always_ff @(posedge clk) begin
    if (g_ready && mv[N]) begin
      g_mag  <= gain_prod[W+15:16];
      g_pass <= mpass[N];
      g_tag  <= mtag[N];
    end
  end

  assign g_pass_q16 = signed'({{(W-SB-16){1'b0}}, g_pass, 16'd0});
  assign av[0]      = g_valid;
  assign axv[0]     = g_tag.pass_is_den ? g_pass_q16 : signed'(g_mag);
  assign ayv[0]     = g_tag.pass_is_den ? signed'(g_mag) : g_pass_q16;
  assign azv[0]     = '0;
  assign atag[0]    = g_tag;

  for (genvar i = 0; i < N; i++) begin : g_ang_row
    tilt_ang_cell #(
      .W     (W),
      .SHIFT (i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (av[i]),
      .in_ready  (ar[i]),
      .in_x      (axv[i]),
      .in_y      (ayv[i]),
      .in_z      (azv[i]),
      .in_tag    (atag[i]),
      .out_valid (av[i+1]),
      .out_ready (ar[i+1]),
      .out_x     (axv[i+1]),
      .out_y     (ayv[i+1]),
      .out_z     (azv[i+1]),
      .out_tag   (atag[i+1])
    );
  end

  tilt_deg u_deg (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (av[N]),
    .in_ready  (ar[N]),
    .in_z      (azv[N]),
    .in_tag    (atag[N]),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_angle (m_tdata),
    .out_undef (m_tuser[0])
  );

  // An empty or draining output register must leave every stage free to move.
  assert property (@(posedge clk) disable iff (rst)
    (m_tready || !m_tvalid) |-> s_tready)
    else $error("input stalled while the output side can move");

  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (m_tdata == 8'd0))
    else $error("undefined result with a nonzero angle");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((signed'(m_tdata) >= -90) && (signed'(m_tdata) <= 90)))
    else $error("angle outside of -90 to 90 degrees");

endmodule
